// ===== src/assert_macros.svh =====
// Assertion macros used by the rows core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== src/ted_pkg.sv =====
// Types, codes and helper functions of the trie edit distance block.
package ted_pkg;

  localparam int CHAR_W  = 21;
  localparam int VAL_W   = 6;
  localparam int ROW_MAX = 63;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_QCHAR = 2'd1,
    OP_DCHAR = 2'd2,
    OP_NOP   = 2'd3
  } ted_op_e;

  typedef enum logic {
    CFG_ALGORITHM = 1'b0,
    CFG_CASE_SENS = 1'b1
  } ted_cfg_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [5:0]        position;
    logic [CHAR_W-1:0] char_code;
    logic [15:0]       word_id;
    logic              last;
  } ted_req_t;

  typedef struct packed {
    logic [15:0]      result_word_id;
    logic [VAL_W-1:0] distance;
  } ted_rsp_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic cap;  // capture the previous rows
    logic en;   // compute this column
    logic dam;  // transposition term allowed here
    logic cs;   // exact compare
  } ted_cell_ctl_t;

  typedef struct packed {
    logic [CHAR_W-1:0] lo;
    logic [CHAR_W-1:0] hi;
    logic              pair;
    logic signed [31:0] delta;
  } fold_rng_t;

  localparam int FOLD_N = 29;

  localparam fold_rng_t FOLD_TABLE [FOLD_N] = '{
    '{21'h41,    21'h5A,    1'b0, 32},
    '{21'hC0,    21'hD6,    1'b0, 32},
    '{21'hD8,    21'hDE,    1'b0, 32},
    '{21'h100,   21'h12F,   1'b1, 1},
    '{21'h130,   21'h130,   1'b0, -199},
    '{21'h132,   21'h137,   1'b1, 1},
    '{21'h139,   21'h148,   1'b1, 1},
    '{21'h14A,   21'h177,   1'b1, 1},
    '{21'h178,   21'h178,   1'b0, -121},
    '{21'h179,   21'h17E,   1'b1, 1},
    '{21'h386,   21'h386,   1'b0, 38},
    '{21'h388,   21'h38A,   1'b0, 37},
    '{21'h38C,   21'h38C,   1'b0, 64},
    '{21'h38E,   21'h38F,   1'b0, 63},
    '{21'h391,   21'h3A1,   1'b0, 32},
    '{21'h3A3,   21'h3AB,   1'b0, 32},
    '{21'h400,   21'h40F,   1'b0, 80},
    '{21'h410,   21'h42F,   1'b0, 32},
    '{21'h460,   21'h481,   1'b1, 1},
    '{21'h48A,   21'h4BF,   1'b1, 1},
    '{21'h4C0,   21'h4C0,   1'b0, 15},
    '{21'h4C1,   21'h4CE,   1'b1, 1},
    '{21'h4D0,   21'h52F,   1'b1, 1},
    '{21'h531,   21'h556,   1'b0, 48},
    '{21'h1E00,  21'h1E95,  1'b1, 1},
    '{21'h1E9E,  21'h1E9E,  1'b0, -7615},
    '{21'h1EA0,  21'h1EFF,  1'b1, 1},
    '{21'hFF21,  21'hFF3A,  1'b0, 32},
    '{21'h10400, 21'h10427, 1'b0, 40}
  };

  // Simple lower-case mapping; codes outside the table map to themselves.
  function automatic logic [CHAR_W-1:0] fold_lower(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    logic              hit;
    r   = c;
    hit = 1'b0;
    for (int i = 0; i < FOLD_N; i++) begin
      if (!hit && c >= FOLD_TABLE[i].lo && c <= FOLD_TABLE[i].hi) begin
        hit = 1'b1;
        if (FOLD_TABLE[i].pair) begin
          r = ((c[0] ^ FOLD_TABLE[i].lo[0]) == 1'b0) ? CHAR_W'(c + 1'b1) : c;
        end else begin
          r = CHAR_W'($signed({11'b0, c}) + FOLD_TABLE[i].delta);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] sat_inc(logic [VAL_W-1:0] v);
    return (v == VAL_W'(ROW_MAX)) ? v : VAL_W'(v + 1'b1);
  endfunction

endpackage

// ===== src/ted_if.sv =====
// Request and result channel interfaces of the trie edit distance block.
interface ted_in_if;
  logic              valid;
  logic              ready;
  ted_pkg::ted_req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface ted_out_if;
  logic              valid;
  logic              ready;
  ted_pkg::ted_rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

// ===== src/ted_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ted_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ted_cell.sv =====
// One query column of the edit distance row: holds its query character.
module ted_cell (
  input  logic                           clk_i,
  input  ted_pkg::ted_cell_ctl_t         ctl_i,
  input  logic                           q_we_i,
  input  logic [ted_pkg::CHAR_W-1:0]     q_raw_i,
  input  logic [ted_pkg::CHAR_W-1:0]     q_fold_i,
  input  logic [ted_pkg::CHAR_W-1:0]     nb_char_i,
  input  logic [ted_pkg::CHAR_W-1:0]     ch_i,
  input  logic [ted_pkg::CHAR_W-1:0]     dprev_i,
  input  logic [ted_pkg::VAL_W-1:0]      prow_i,
  input  logic [ted_pkg::VAL_W-1:0]      pp_i,
  input  logic [ted_pkg::VAL_W-1:0]      diag_i,
  input  logic [ted_pkg::VAL_W-1:0]      left_i,
  output logic [ted_pkg::CHAR_W-1:0]     qsel_o,
  output logic [ted_pkg::VAL_W-1:0]      prow_o,
  output logic [ted_pkg::VAL_W-1:0]      val_o
);
  import ted_pkg::*;

  logic [CHAR_W-1:0] q_raw_q, q_fold_q;
  logic [VAL_W-1:0]  prow_q, pp_q, val_q, val_d;
  logic [VAL_W-1:0]  m1, m2, base, trans;
  logic              swap;

  always_ff @(posedge clk_i) begin
    if (q_we_i) begin
      q_raw_q  <= q_raw_i;
      q_fold_q <= q_fold_i;
    end
    if (ctl_i.cap) begin
      prow_q <= prow_i;
      pp_q   <= pp_i;
    end
    if (ctl_i.en) begin
      val_q <= val_d;
    end
  end

  assign qsel_o = ctl_i.cs ? q_raw_q : q_fold_q;

  always_comb begin
    m1    = (left_i < prow_q) ? left_i : prow_q;
    m2    = (m1 < diag_i) ? m1 : diag_i;
    base  = (ch_i == qsel_o) ? diag_i : sat_inc(m2);
    trans = sat_inc(pp_q);
    swap  = ctl_i.dam && (dprev_i == qsel_o) && (ch_i == nb_char_i) &&
            (nb_char_i != qsel_o);
    val_d = (swap && trans < base) ? trans : base;
  end

  assign prow_o = prow_q;
  assign val_o  = val_q;

endmodule

// ===== src/trie_edit_distance_rows_core.sv =====
// Start query and query character requests complete when they are accepted.
// A dictionary character runs through a row read, one column per cycle along the
// cell chain (n = query length, up to 32 at the default size), and a row write.
// The next request is taken once the row is written; a word-ending character whose
// result cannot yet enter the occupied result register holds the input until it can.
// Reset clears the sequencer, configuration, query length and result valid;
// query characters and the row and depth memories are undefined until written.
module trie_edit_distance_rows_core #(
  parameter int MAX_QUERY_LEN = 32,
  parameter int MAX_WORD_LEN  = 32,
  parameter int WORD_ID_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ted_in_if.sink        in_i,
  ted_out_if.source     out_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic          cfg_data_i
);
  import ted_pkg::*;
  `include "assert_macros.svh"

  localparam int QLW   = $clog2(MAX_QUERY_LEN + 1);
  localparam int DW    = $clog2(MAX_WORD_LEN + 1);
  localparam int ROW_W = (MAX_QUERY_LEN + 1) * VAL_W;
  localparam logic [15:0] WID_MASK = (WORD_ID_BITS >= 16) ? 16'hFFFF :
                                     16'((32'd1 << WORD_ID_BITS) - 32'd1);

  // Sequencer states: idle, read rows, sweep columns, write row back.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_WRB  = 4'b1000
  } ted_state_e;

  ted_state_e state_q, state_d;

  logic              alg_q, cs_q;
  logic [QLW-1:0]    qlen_q, qlen_d;
  logic [QLW-1:0]    step_q, step_d;
  logic [DW-1:0]     d_q;
  logic              dam_q, last_q;
  logic [15:0]       wid_q;
  logic [CHAR_W-1:0] ch_sel_q;
  logic              out_valid_q;
  ted_rsp_t          rsp_q;

  logic              accept, depth_ok, dchar_go;
  ted_op_e           op;
  logic [DW-1:0]     d_in;
  logic [CHAR_W-1:0] ch_fold;

  logic              row_we;
  logic [DW-1:0]     row_waddr;
  logic [ROW_W-1:0]  row_wdata, row0_vec, row_vals, rd1, rd2;
  logic [2*CHAR_W-1:0] drd;
  logic [CHAR_W-1:0] dprev_sel, dprev_q;

  logic [VAL_W-1:0]  vals  [MAX_QUERY_LEN + 1];
  logic [VAL_W-1:0]  prows [MAX_QUERY_LEN + 1];
  logic [CHAR_W-1:0] qsel  [MAX_QUERY_LEN + 1];
  logic [VAL_W-1:0]  val0_q, prow0_q;
  logic              out_load;

  // Request decode.
  assign accept   = in_i.valid && in_i.ready;
  assign op       = ted_op_e'(in_i.req.opcode);
  assign d_in     = DW'(in_i.req.position);
  assign ch_fold  = fold_lower(in_i.req.char_code);
  assign depth_ok = (in_i.req.position != 6'd0) &&
                    (int'(in_i.req.position) <= MAX_WORD_LEN);
  assign dchar_go = accept && (op == OP_DCHAR) && depth_ok;
  assign qlen_d   = (int'(in_i.req.position) > MAX_QUERY_LEN) ?
                    QLW'(MAX_QUERY_LEN) : QLW'(in_i.req.position);

  // New requests are taken only between dictionary characters.
  assign in_i.ready = (state_q == ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q <= 1'b0;
      cs_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (ted_cfg_e'(cfg_idx_i))
        CFG_ALGORITHM: alg_q <= cfg_data_i;
        CFG_CASE_SENS: cs_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Row zero of a new query is 0, 1, ..., saturated.
  always_comb begin
    for (int k = 0; k <= MAX_QUERY_LEN; k++) begin
      row0_vec[k*VAL_W +: VAL_W] = VAL_W'((k > ROW_MAX) ? ROW_MAX : k);
      row_vals[k*VAL_W +: VAL_W] = vals[k];
    end
  end

  // The row store is kept twice so that rows d-1 and d-2 read together.
  assign row_we    = (accept && op == OP_START) || (state_q == ST_WRB);
  assign row_waddr = (state_q == ST_WRB) ? d_q : '0;
  assign row_wdata = (state_q == ST_WRB) ? row_vals : row0_vec;

  ted_ram #(.WIDTH(ROW_W), .DEPTH(MAX_WORD_LEN + 1)) u_row_prev (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (DW'(d_in - DW'(1))),
    .rdata_o (rd1)
  );

  ted_ram #(.WIDTH(ROW_W), .DEPTH(MAX_WORD_LEN + 1)) u_row_prev2 (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (DW'(d_in - DW'(2))),
    .rdata_o (rd2)
  );

  // Dictionary character per depth, stored exact and folded.
  ted_ram #(.WIDTH(2 * CHAR_W), .DEPTH(MAX_WORD_LEN + 1)) u_depth_chars (
    .clk_i   (clk_i),
    .we_i    (dchar_go),
    .waddr_i (d_in),
    .wdata_i ({in_i.req.char_code, ch_fold}),
    .raddr_i (DW'(d_in - DW'(1))),
    .rdata_o (drd)
  );

  assign dprev_sel = cs_q ? drd[2*CHAR_W-1:CHAR_W] : drd[CHAR_W-1:0];

  // Column zero lives here: it only counts depth. The character one level up is
  // held for the whole sweep, since the read port follows the next request.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      prow0_q <= rd1[VAL_W-1:0];
      val0_q  <= sat_inc(rd1[VAL_W-1:0]);
      dprev_q <= dprev_sel;
    end
    if (dchar_go) begin
      d_q      <= d_in;
      dam_q    <= alg_q && (in_i.req.position >= 6'd2);
      last_q   <= in_i.req.last;
      wid_q    <= in_i.req.word_id & WID_MASK;
      ch_sel_q <= cs_q ? in_i.req.char_code : ch_fold;
    end
  end

  assign vals[0]  = val0_q;
  assign prows[0] = prow0_q;
  assign qsel[0]  = '0;

  // Chain of column cells; the left value walks one cell per cycle.
  for (genvar k = 1; k <= MAX_QUERY_LEN; k++) begin : g_cell
    ted_cell_ctl_t     ctl;
    logic [VAL_W-1:0]  pp;

    assign ctl.cap = (state_q == ST_LOAD);
    assign ctl.en  = (state_q == ST_RUN) && (step_q == QLW'(k));
    assign ctl.dam = dam_q && (k >= 2);
    assign ctl.cs  = cs_q;

    if (k >= 2) begin : g_pp
      assign pp = rd2[(k-2)*VAL_W +: VAL_W];
    end else begin : g_nopp
      assign pp = '0;
    end

    ted_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .q_we_i    (accept && (op == OP_QCHAR) && (int'(in_i.req.position) == k)),
      .q_raw_i   (in_i.req.char_code),
      .q_fold_i  (ch_fold),
      .nb_char_i (qsel[k-1]),
      .ch_i      (ch_sel_q),
      .dprev_i   (dprev_q),
      .prow_i    (rd1[k*VAL_W +: VAL_W]),
      .pp_i      (pp),
      .diag_i    (prows[k-1]),
      .left_i    (vals[k-1]),
      .qsel_o    (qsel[k]),
      .prow_o    (prows[k]),
      .val_o     (vals[k])
    );
  end

  // Sequencer.
  assign out_load = (state_q == ST_WRB) && last_q && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (dchar_go) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        step_d  = QLW'(1);
        state_d = (qlen_q == '0) ? ST_WRB : ST_RUN;
      end
      ST_RUN: begin
        if (step_q == qlen_q) begin
          state_d = ST_WRB;
        end else begin
          step_d = QLW'(step_q + 1'b1);
        end
      end
      ST_WRB: begin
        // A finished word waits here until the result register is free.
        if (!last_q || out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      qlen_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (accept && op == OP_START) begin
        qlen_q <= qlen_d;
      end
    end
  end

  // Result register between the sweep and the consumer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_q.result_word_id <= wid_q;
      rsp_q.distance       <= vals[qlen_q];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.rsp   = rsp_q;

  // The sweep never runs past the query length.
  `ASSERT_PROP(a_step_range, clk_i, rst_ni,
               (state_q == ST_RUN) |-> (step_q != '0 && step_q <= qlen_q))
  // Row read is always followed by the sweep or the write-back.
  `ASSERT_PROP(a_load_next, clk_i, rst_ni,
               (state_q == ST_LOAD) |=> (state_q == ST_RUN || state_q == ST_WRB))
  // A dictionary character in range always starts a row update.
  `ASSERT_PROP(a_dchar_start, clk_i, rst_ni, dchar_go |=> (state_q == ST_LOAD))

endmodule
